// ----- hw/rtl/gmdb_pkg.sv -----
// Shared types and constants for the gradient magnitude/direction binner.
package gmdb_pkg;

    localparam int COUNT_BITS = 22;
    localparam int OUT_CNT_W  = 22;

    localparam int PIX_W  = 8;
    localparam int GRAD_W = 12;      // signed sx/sy, |s| <= 1020
    localparam int ABS_W  = 10;
    localparam int MUL_A_W = 11;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUMSQ_W = 21;     // ax^2 + ay^2 <= 2,080,800
    localparam int RAD_W   = 22;     // radicand padded to an even width
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int STEP_W  = $clog2(SQRT_STEPS);
    localparam int MAG_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int LHS_SHIFT  = 16;

    // tan(22.5) and tan(67.5) in unsigned Q16
    localparam logic [MUL_B_W-1:0] TAN_22_5_Q16 = MUL_B_W'(27146);
    localparam logic [MUL_B_W-1:0] TAN_67_5_Q16 = MUL_B_W'(158218);
    // floor(r/6) == (r * RECIP_6) >> RECIP_SHIFT for r < 2^16
    localparam logic [MUL_B_W-1:0] RECIP_6     = MUL_B_W'(43691);
    localparam int                 RECIP_SHIFT = 18;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SELECT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAG_THRESHOLD = CFG_IDX_W'(1);

    localparam logic             KERNEL_RESET    = 1'b1;
    localparam logic [MAG_W-1:0] THRESHOLD_RESET = MAG_W'(50);

    typedef enum logic [1:0] {
        DIR_FLAT  = 2'd0,
        DIR_DIAG  = 2'd1,
        DIR_OTHER = 2'd2
    } t_dir;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_TAN1,
        S_TAN3,
        S_ROOT,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic en;
        logic clear;
        logic is_strong;
        t_dir dir;
    } t_cnt_upd;

endpackage

// ----- hw/rtl/gmdb_isqrt.sv -----
// Iterative restoring integer square root, one result bit per cycle.
module gmdb_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gmdb_pkg::RAD_W-1:0]  i_radicand,
    output logic                        o_busy,
    output logic [gmdb_pkg::ROOT_W-1:0] o_root
);
    import gmdb_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SQRT_STEPS - 1);

    logic [RAD_W-1:0]  r_op;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    always_comb begin
        // remainder stays below 2*root+1, so its top two bits are free here
        rem_sh = {r_rem[REM_W-3:0], r_op[RAD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_busy <= (r_step != LAST_STEP);
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_op   <= {r_op[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

    a_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && (r_step == '0))
        else $error("isqrt not busy after start");

    a_fall_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_step) == LAST_STEP)
        else $error("isqrt finished early");

    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_busy) && !$past(i_start)) |-> ({1'b0, r_rem} <= {r_root, 1'b0}))
        else $error("isqrt remainder out of range");

endmodule

// ----- hw/rtl/gmdb_counters.sv -----
// Five saturating frame counters for the strength and direction bins.
module gmdb_counters (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gmdb_pkg::t_cnt_upd              i_upd,
    output logic [gmdb_pkg::COUNT_BITS-1:0] o_next_weak,
    output logic [gmdb_pkg::COUNT_BITS-1:0] o_next_strong,
    output logic [gmdb_pkg::COUNT_BITS-1:0] o_next_flat,
    output logic [gmdb_pkg::COUNT_BITS-1:0] o_next_diag,
    output logic [gmdb_pkg::COUNT_BITS-1:0] o_next_other
);
    import gmdb_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam int SUM_W = COUNT_BITS + 2;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    logic [COUNT_BITS-1:0] r_weak, r_strong, r_flat, r_diag, r_other;
    logic [COUNT_BITS-1:0] n_weak, n_strong, n_flat, n_diag, n_other;
    logic [COUNT_BITS-1:0] b_weak, b_strong, b_flat, b_diag, b_other;
    logic                  clr;
    logic                  hit_flat, hit_diag, hit_other;

    always_comb begin
        clr = i_upd.en && i_upd.clear;
        b_weak   = clr ? '0 : r_weak;
        b_strong = clr ? '0 : r_strong;
        b_flat   = clr ? '0 : r_flat;
        b_diag   = clr ? '0 : r_diag;
        b_other  = clr ? '0 : r_other;

        hit_flat  = 1'b0;
        hit_diag  = 1'b0;
        hit_other = 1'b0;
        case (i_upd.dir)
            DIR_FLAT: hit_flat  = 1'b1;
            DIR_DIAG: hit_diag  = 1'b1;
            default:  hit_other = 1'b1;
        endcase

        n_weak   = (i_upd.en && !i_upd.is_strong) ? sat_inc(b_weak)   : b_weak;
        n_strong = (i_upd.en &&  i_upd.is_strong) ? sat_inc(b_strong) : b_strong;
        n_flat   = (i_upd.en && hit_flat)      ? sat_inc(b_flat)   : b_flat;
        n_diag   = (i_upd.en && hit_diag)      ? sat_inc(b_diag)   : b_diag;
        n_other  = (i_upd.en && hit_other)     ? sat_inc(b_other)  : b_other;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weak   <= '0;
            r_strong <= '0;
            r_flat   <= '0;
            r_diag   <= '0;
            r_other  <= '0;
        end else begin
            r_weak   <= n_weak;
            r_strong <= n_strong;
            r_flat   <= n_flat;
            r_diag   <= n_diag;
            r_other  <= n_other;
        end
    end

    assign o_next_weak   = n_weak;
    assign o_next_strong = n_strong;
    assign o_next_flat   = n_flat;
    assign o_next_diag   = n_diag;
    assign o_next_other  = n_other;

    a_clear_strength : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd.en && i_upd.clear) |=> (SUM_W'(r_weak) + SUM_W'(r_strong)) == SUM_W'(1))
        else $error("strength counters wrong after frame start");

    a_clear_dir : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd.en && i_upd.clear) |=>
            (SUM_W'(r_flat) + SUM_W'(r_diag) + SUM_W'(r_other)) == SUM_W'(1))
        else $error("direction counters wrong after frame start");

    a_hold_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_upd.en |=> $stable(r_weak) && $stable(r_strong) && $stable(r_flat))
        else $error("counter moved without an update");

endmodule

// ----- hw/rtl/gradient_magnitude_direction_binner_unit.sv -----
// Top level: Prewitt/Sobel gradient magnitude, direction class and frame bins.
//
// One 3x3 neighborhood is taken per input beat, and the block then holds
// o_in_stall high until the item is finished. A single 11x18 multiplier is
// reused for ax^2, ay^2, the two tan comparisons and the divide by six, and
// the 11-step restoring square root (one result bit per cycle) takes most of
// the time spent on an item. The finished result sits in an output register,
// so the next beat is taken while it waits to be drained; a stalled output
// only holds the block in its last state. Configuration writes take effect
// at once and are meant for idle periods.
module gradient_magnitude_direction_binner_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gmdb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gmdb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [gmdb_pkg::PIX_W-1:0]         i_pix_top_left,
    input  logic [gmdb_pkg::PIX_W-1:0]         i_pix_top_mid,
    input  logic [gmdb_pkg::PIX_W-1:0]         i_pix_top_right,
    input  logic [gmdb_pkg::PIX_W-1:0]         i_pix_mid_left,
    input  logic [gmdb_pkg::PIX_W-1:0]         i_pix_center,
    input  logic [gmdb_pkg::PIX_W-1:0]         i_pix_mid_right,
    input  logic [gmdb_pkg::PIX_W-1:0]         i_pix_bottom_left,
    input  logic [gmdb_pkg::PIX_W-1:0]         i_pix_bottom_mid,
    input  logic [gmdb_pkg::PIX_W-1:0]         i_pix_bottom_right,
    input  logic                               i_frame_start,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [gmdb_pkg::MAG_W-1:0]         o_magnitude,
    output logic                               o_strong_edge,
    output logic [1:0]                         o_direction_class,
    output logic [gmdb_pkg::OUT_CNT_W-1:0]     o_count_weak,
    output logic [gmdb_pkg::OUT_CNT_W-1:0]     o_count_strong,
    output logic [gmdb_pkg::OUT_CNT_W-1:0]     o_count_dir_flat,
    output logic [gmdb_pkg::OUT_CNT_W-1:0]     o_count_dir_diag,
    output logic [gmdb_pkg::OUT_CNT_W-1:0]     o_count_dir_other
);
    import gmdb_pkg::*;

    // configuration
    logic             r_kernel;
    logic [MAG_W-1:0] r_thr;

    // control
    t_state r_state, n_state;
    logic   r_out_valid;

    // datapath
    logic [ABS_W-1:0]   r_ax, r_ay;
    logic               r_sx_pos, r_grad_zero, r_frame_start;
    logic [PROD_W-1:0]  r_prod;
    logic [SUMSQ_W-1:0] r_acc;
    logic               r_le1, r_lt3;

    // output register
    logic [MAG_W-1:0]     r_magnitude;
    logic                 r_strong;
    t_dir                 r_dir;
    logic [OUT_CNT_W-1:0] r_cnt_weak, r_cnt_strong, r_cnt_flat, r_cnt_diag, r_cnt_other;

    // combinational
    logic                in_accept, out_free;
    logic signed [GRAD_W-1:0] sx, sy, w_mid;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   product;
    logic                mul_en;
    logic [PROD_W-1:0]   lhs;
    logic                sqrt_start, sqrt_busy;
    logic [ROOT_W-1:0]   sqrt_root;
    logic [MAG_W-1:0]    mag_now;
    logic                strong_now;
    t_dir                dir_now;
    logic                load_out;
    t_cnt_upd            cnt_upd;
    logic [COUNT_BITS-1:0] nc_weak, nc_strong, nc_flat, nc_diag, nc_other;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // gradient sums straight from the input ports
    always_comb begin
        w_mid = r_kernel ? GRAD_W'(2) : GRAD_W'(1);
        sx = GRAD_W'(i_pix_top_right) + w_mid * GRAD_W'(i_pix_mid_right)
           + GRAD_W'(i_pix_bottom_right)
           - GRAD_W'(i_pix_top_left) - w_mid * GRAD_W'(i_pix_mid_left)
           - GRAD_W'(i_pix_bottom_left);
        sy = GRAD_W'(i_pix_top_left) + w_mid * GRAD_W'(i_pix_top_mid)
           + GRAD_W'(i_pix_top_right)
           - GRAD_W'(i_pix_bottom_left) - w_mid * GRAD_W'(i_pix_bottom_mid)
           - GRAD_W'(i_pix_bottom_right);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_SQX;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_TAN1;
            S_TAN1: n_state = S_TAN3;
            S_TAN3: n_state = S_ROOT;
            S_ROOT: if (!sqrt_busy) n_state = S_DIV;
            S_DIV:  n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands and strobes
    always_comb begin
        o_in_stall = 1'b1;
        mul_a      = MUL_A_W'(r_ax);
        mul_b      = MUL_B_W'(r_ax);
        mul_en     = 1'b0;
        sqrt_start = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_SQX:  mul_en = 1'b1;
            S_SQY: begin
                mul_a  = MUL_A_W'(r_ay);
                mul_b  = MUL_B_W'(r_ay);
                mul_en = 1'b1;
            end
            S_TAN1: begin
                mul_b  = TAN_22_5_Q16;
                mul_en = 1'b1;
            end
            S_TAN3: begin
                mul_b      = TAN_67_5_Q16;
                mul_en     = 1'b1;
                sqrt_start = 1'b1;
            end
            S_DIV: begin
                mul_a  = sqrt_root;
                mul_b  = RECIP_6;
                mul_en = 1'b1;
            end
            S_DONE: load_out = out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign lhs     = PROD_W'({r_ay, {LHS_SHIFT{1'b0}}});

    // final classification, valid in S_DONE
    always_comb begin
        mag_now    = r_prod[RECIP_SHIFT +: MAG_W];
        strong_now = mag_now >= r_thr;
        if (r_grad_zero) begin
            dir_now = DIR_FLAT;
        end else if (!r_sx_pos) begin
            dir_now = DIR_OTHER;
        end else if (r_le1) begin
            dir_now = DIR_FLAT;
        end else if (r_lt3) begin
            dir_now = DIR_DIAG;
        end else begin
            dir_now = DIR_OTHER;
        end
        cnt_upd.en        = load_out;
        cnt_upd.clear     = r_frame_start;
        cnt_upd.is_strong = strong_now;
        cnt_upd.dir       = dir_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_kernel    <= KERNEL_RESET;
            r_thr       <= THRESHOLD_RESET;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KERNEL_SELECT: r_kernel <= i_cfg_data[0];
                    REG_MAG_THRESHOLD: r_thr    <= i_cfg_data[MAG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ax          <= ABS_W'(sx < 0 ? -sx : sx);
            r_ay          <= ABS_W'(sy < 0 ? -sy : sy);
            r_sx_pos      <= sx > 0;
            r_grad_zero   <= (sx == 0) && (sy == 0);
            r_frame_start <= i_frame_start;
        end
        if (mul_en) begin
            r_prod <= product;
        end
        // the product registered in one state is consumed in the next state
        case (r_state)
            S_SQY:  r_acc <= r_prod[SUMSQ_W-1:0];
            S_TAN1: r_acc <= r_acc + r_prod[SUMSQ_W-1:0];
            S_TAN3: r_le1 <= lhs <= r_prod;
            S_ROOT: r_lt3 <= lhs < r_prod;
            default: ;
        endcase
        if (load_out) begin
            r_magnitude  <= mag_now;
            r_strong     <= strong_now;
            r_dir        <= dir_now;
            r_cnt_weak   <= OUT_CNT_W'(nc_weak);
            r_cnt_strong <= OUT_CNT_W'(nc_strong);
            r_cnt_flat   <= OUT_CNT_W'(nc_flat);
            r_cnt_diag   <= OUT_CNT_W'(nc_diag);
            r_cnt_other  <= OUT_CNT_W'(nc_other);
        end
    end

    gmdb_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (RAD_W'(r_acc)),
        .o_busy     (sqrt_busy),
        .o_root     (sqrt_root)
    );

    gmdb_counters u_counters (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upd         (cnt_upd),
        .o_next_weak   (nc_weak),
        .o_next_strong (nc_strong),
        .o_next_flat   (nc_flat),
        .o_next_diag   (nc_diag),
        .o_next_other  (nc_other)
    );

    assign o_out_valid       = r_out_valid;
    assign o_magnitude       = r_magnitude;
    assign o_strong_edge     = r_strong;
    assign o_direction_class = r_dir;
    assign o_count_weak      = r_cnt_weak;
    assign o_count_strong    = r_cnt_strong;
    assign o_count_dir_flat  = r_cnt_flat;
    assign o_count_dir_diag  = r_cnt_diag;
    assign o_count_dir_other = r_cnt_other;

    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_SQX)
        else $error("accepted beat did not start the sequence");

    a_result_from_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result appeared outside the final state");

    a_mag_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_magnitude <= MAG_W'(240))
        else $error("magnitude out of range");

    a_root_before_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !sqrt_busy)
        else $error("divide started before square root finished");

endmodule
